FILE: src/crs_pkg.sv
// shared constants, codes and types of the coil bit range store
package crs_pkg;

  localparam int NUM_COILS   = 2048;
  localparam int BYTE_BITS   = 8;
  localparam int OFF_W       = $clog2(BYTE_BITS);
  localparam int STORE_BYTES = (NUM_COILS + BYTE_BITS - 1) / BYTE_BITS;
  localparam int BANK_DEPTH  = (STORE_BYTES + 1) / 2;
  localparam int BIDX_W      = $clog2(STORE_BYTES);
  localparam int BANK_AW     = $clog2(BANK_DEPTH);
  localparam int CIU_W       = 12;
  localparam int ADDR_W      = 16;
  localparam int CNT_W       = 16;
  localparam int CHUNK_W     = 8;
  localparam int SUM_W       = ADDR_W + 1;
  localparam int NBITS_W     = OFF_W + 1;

  localparam logic [CIU_W-1:0] CIU_RESET = CIU_W'(2048);

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_RANGE  = 2'd1,
    ST_BEYOND = 2'd2
  } status_t;

  // decoded chunk, held for the merge stage
  typedef struct packed {
    logic                 op_wr;
    status_t              status;
    logic [OFF_W-1:0]     off;
    logic [BYTE_BITS-1:0] nmask;
    logic [BYTE_BITS-1:0] wdata;
    logic                 lo_odd;
    logic                 hi_en;
    logic [BANK_AW-1:0]   ev_addr;
    logic [BANK_AW-1:0]   od_addr;
  } decode_t;

  // one bank write, also registered for forwarding
  typedef struct packed {
    logic                 en;
    logic [BANK_AW-1:0]   addr;
    logic [BYTE_BITS-1:0] data;
  } bank_wr_t;

  typedef struct packed {
    status_t              status;
    logic [BYTE_BITS-1:0] read_byte;
  } out_item_t;

endpackage

FILE: src/crs_ram.sv
// generic single write port ram with registered read
module crs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/crs_decode.sv
// range checks and byte address decode of one chunk
module crs_decode (
  input  logic                          op,
  input  logic [crs_pkg::ADDR_W-1:0]    start_address,
  input  logic [crs_pkg::CNT_W-1:0]     bit_count,
  input  logic [crs_pkg::CHUNK_W-1:0]   chunk_index,
  input  logic [crs_pkg::BYTE_BITS-1:0] write_byte,
  input  logic [crs_pkg::CIU_W-1:0]     coils_in_use,
  output crs_pkg::decode_t              dec
);
  import crs_pkg::*;

  logic [SUM_W-1:0]          sum;
  logic [SUM_W-1:0]          lim;
  logic [CNT_W-1:0]          first;
  logic [CNT_W-1:0]          rem;
  logic [NBITS_W-1:0]        nbits;
  logic [SUM_W-1:0]          base;
  logic [BIDX_W-1:0]         bidx;
  logic [BANK_AW-1:0]        half;
  logic [BYTE_BITS-1:0]      nmask;

  always_comb begin
    sum   = SUM_W'(start_address) + SUM_W'(bit_count);
    lim   = (SUM_W'(coils_in_use) > SUM_W'(NUM_COILS)) ? SUM_W'(NUM_COILS)
                                                       : SUM_W'(coils_in_use);
    first = CNT_W'({chunk_index, OFF_W'(0)});
    rem   = bit_count - first;
    nbits = (rem > CNT_W'(BYTE_BITS)) ? NBITS_W'(BYTE_BITS) : rem[NBITS_W-1:0];
    nmask = {BYTE_BITS{1'b1}} >> (NBITS_W'(BYTE_BITS) - nbits);
    base  = SUM_W'(start_address) + SUM_W'(first);
    bidx  = base[BIDX_W+OFF_W-1:OFF_W];
    half  = BANK_AW'(bidx >> 1);

    dec.op_wr = (op == OP_WRITE);
    if (bit_count == '0 || sum > lim) begin
      dec.status = ST_RANGE;
    end else if (first >= bit_count) begin
      dec.status = ST_BEYOND;
    end else begin
      dec.status = ST_OK;
    end
    dec.off     = base[OFF_W-1:0];
    dec.nmask   = nmask;
    dec.wdata   = write_byte & nmask;
    dec.lo_odd  = bidx[0];
    dec.hi_en   = (SUM_W'(bidx) + SUM_W'(1)) < SUM_W'(STORE_BYTES);
    // odd low byte: high byte sits in the even bank one row up
    dec.ev_addr = bidx[0] ? (half + BANK_AW'(1)) : half;
    dec.od_addr = half;
  end

endmodule

FILE: src/crs_merge.sv
// read extract and read-modify-write merge of the two bank bytes
module crs_merge (
  input  logic                          s1_vld,
  input  crs_pkg::decode_t              dec,
  input  logic [crs_pkg::BYTE_BITS-1:0] ev_raw,
  input  logic [crs_pkg::BYTE_BITS-1:0] od_raw,
  input  logic                          ev_vld,
  input  logic                          od_vld,
  input  crs_pkg::bank_wr_t             ev_fwd,
  input  crs_pkg::bank_wr_t             od_fwd,
  output crs_pkg::out_item_t            res,
  output crs_pkg::bank_wr_t             ev_wr,
  output crs_pkg::bank_wr_t             od_wr
);
  import crs_pkg::*;

  localparam int WIDE_W = 2 * BYTE_BITS;

  logic [BYTE_BITS-1:0] ev_eff;
  logic [BYTE_BITS-1:0] od_eff;
  logic [BYTE_BITS-1:0] lo;
  logic [BYTE_BITS-1:0] hi;
  logic [WIDE_W-1:0]    wide;
  logic [WIDE_W-1:0]    m;
  logic [WIDE_W-1:0]    d;
  logic [BYTE_BITS-1:0] new_lo;
  logic [BYTE_BITS-1:0] new_hi;
  logic                 do_wr;
  logic                 lo_we;
  logic                 hi_we;

  always_comb begin
    // never written reads as zero, last cycle's write is forwarded
    ev_eff = (ev_fwd.en && ev_fwd.addr == dec.ev_addr) ? ev_fwd.data
           : (ev_vld ? ev_raw : '0);
    od_eff = (od_fwd.en && od_fwd.addr == dec.od_addr) ? od_fwd.data
           : (od_vld ? od_raw : '0);
    lo   = dec.lo_odd ? od_eff : ev_eff;
    hi   = dec.hi_en ? (dec.lo_odd ? ev_eff : od_eff) : '0;
    wide = {hi, lo};
    m    = WIDE_W'(dec.nmask) << dec.off;
    d    = WIDE_W'(dec.wdata) << dec.off;

    new_lo = (lo & ~m[BYTE_BITS-1:0]) | d[BYTE_BITS-1:0];
    new_hi = (hi & ~m[WIDE_W-1:BYTE_BITS]) | d[WIDE_W-1:BYTE_BITS];

    do_wr = s1_vld && dec.op_wr && (dec.status == ST_OK);
    lo_we = do_wr;
    hi_we = do_wr && dec.hi_en && (m[WIDE_W-1:BYTE_BITS] != '0);

    res.status = dec.status;
    if (!dec.op_wr && dec.status == ST_OK) begin
      res.read_byte = BYTE_BITS'(wide >> dec.off) & dec.nmask;
    end else begin
      res.read_byte = '0;
    end

    ev_wr.addr = dec.ev_addr;
    od_wr.addr = dec.od_addr;
    if (dec.lo_odd) begin
      od_wr.en   = lo_we;
      od_wr.data = new_lo;
      ev_wr.en   = hi_we;
      ev_wr.data = new_hi;
    end else begin
      ev_wr.en   = lo_we;
      ev_wr.data = new_lo;
      od_wr.en   = hi_we;
      od_wr.data = new_hi;
    end
  end

endmodule

FILE: src/crs_out_fifo.sv
// three entry result queue in front of the output channel
module crs_out_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  crs_pkg::out_item_t push_item,
  input  logic               pop,
  output logic               not_empty,
  output crs_pkg::out_item_t head,
  output logic [1:0]         cnt
);
  import crs_pkg::*;

  localparam int QDEPTH = 3;

  out_item_t  q_r [QDEPTH];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_pop;

  always_comb begin
    do_pop     = pop && (cnt_r != 2'd0);
    wr_ptr_nxt = push ? ((wr_ptr_r == 2'(QDEPTH - 1)) ? 2'd0 : wr_ptr_r + 2'd1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ((rd_ptr_r == 2'(QDEPTH - 1)) ? 2'd0 : rd_ptr_r + 2'd1)
                        : rd_ptr_r;
    cnt_nxt    = cnt_r + (push ? 2'd1 : 2'd0) - (do_pop ? 2'd1 : 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_item;
    end
  end

  assign not_empty = (cnt_r != 2'd0);
  assign head      = q_r[rd_ptr_r];
  assign cnt       = cnt_r;

endmodule

FILE: src/coil_bit_range_store.sv
// top level of the coil bit range store
// Coil bit range store: one beat on the input channel is one byte chunk of a
// coil transfer, and one beat comes out for it, in order. The input stream
// takes a beat every cycle while the result queue has room; a result reaches the
// output through address decode and bank read in the accept cycle, merge and
// write back in the next, then the result queue. Sustained rate is one chunk per
// clock while the result queue has room, set by the store being split into an
// even and an odd byte bank, each with one write and one read port, so the two
// bytes a chunk touches are read and written in the same cycle; a write made by
// the previous chunk is forwarded to the next. The store reads as all coils off
// after reset at once: per-row valid bits clear with reset, no clearing pass.
// coils_in_use is written on the cfg channel, which is always ready; the user must
// write it only while no transfer is in flight, and the block does not enforce it.
module coil_bit_range_store (
  input  logic        clk,
  input  logic        rst_n,
  // config channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [11:0] cfg_data,   // coils_in_use
  // chunk input
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // start_address, bit_count, chunk_index, write_byte
  input  logic [0:0]  in_tuser,   // op
  // result output
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // read_byte
  output logic [1:0]  out_tuser   // status
);
  import crs_pkg::*;

  // config register
  logic [CIU_W-1:0] coils_in_use_r;

  // input fields
  logic                 in_op;
  logic [ADDR_W-1:0]    in_start_address;
  logic [CNT_W-1:0]     in_bit_count;
  logic [CHUNK_W-1:0]   in_chunk_index;
  logic [BYTE_BITS-1:0] in_write_byte;
  logic                 in_beat;

  // decode and merge stage
  decode_t              dec;
  decode_t              s1_dec_r;
  logic                 s1_vld_r;
  out_item_t            res;
  bank_wr_t             ev_wr;
  bank_wr_t             od_wr;
  bank_wr_t             ev_fwd_r;
  bank_wr_t             od_fwd_r;
  logic [BYTE_BITS-1:0] ev_raw;
  logic [BYTE_BITS-1:0] od_raw;

  // row valid bits, cleared by reset
  logic [BANK_DEPTH-1:0] ev_vld_r;
  logic [BANK_DEPTH-1:0] od_vld_r;

  // result queue
  out_item_t  head;
  logic       q_not_empty;
  logic [1:0] q_cnt;
  logic [2:0] in_flight;

  assign in_op            = in_tuser[0];
  assign in_start_address = in_tdata[15:0];
  assign in_bit_count     = in_tdata[31:16];
  assign in_chunk_index   = in_tdata[39:32];
  assign in_write_byte    = in_tdata[47:40];

  // room for every chunk in flight, so the merge stage never stalls
  assign in_flight = 3'(s1_vld_r) + 3'(q_cnt);
  assign in_tready = (in_flight < 3'd3);
  assign in_beat   = in_tvalid && in_tready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coils_in_use_r <= CIU_RESET;
    end else if (cfg_valid && cfg_ready) begin
      coils_in_use_r <= cfg_data;
    end
  end

  crs_decode u_decode (
    .op            (in_op),
    .start_address (in_start_address),
    .bit_count     (in_bit_count),
    .chunk_index   (in_chunk_index),
    .write_byte    (in_write_byte),
    .coils_in_use  (coils_in_use_r),
    .dec           (dec)
  );

  // even bank holds store bytes 0, 2, 4 ..., odd bank bytes 1, 3, 5 ...
  crs_ram #(
    .WIDTH (BYTE_BITS),
    .DEPTH (BANK_DEPTH)
  ) u_ram_ev (
    .clk   (clk),
    .we    (ev_wr.en),
    .waddr (ev_wr.addr),
    .wdata (ev_wr.data),
    .raddr (dec.ev_addr),
    .rdata (ev_raw)
  );

  crs_ram #(
    .WIDTH (BYTE_BITS),
    .DEPTH (BANK_DEPTH)
  ) u_ram_od (
    .clk   (clk),
    .we    (od_wr.en),
    .waddr (od_wr.addr),
    .wdata (od_wr.data),
    .raddr (dec.od_addr),
    .rdata (od_raw)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      ev_fwd_r <= '0;
      od_fwd_r <= '0;
      ev_vld_r <= '0;
      od_vld_r <= '0;
    end else begin
      s1_vld_r <= in_beat;
      // bank read in the same cycle missed this write, keep it for forwarding
      ev_fwd_r <= ev_wr;
      od_fwd_r <= od_wr;
      if (ev_wr.en) begin
        ev_vld_r[ev_wr.addr] <= 1'b1;
      end
      if (od_wr.en) begin
        od_vld_r[od_wr.addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_dec_r <= dec;
    end
  end

  crs_merge u_merge (
    .s1_vld (s1_vld_r),
    .dec    (s1_dec_r),
    .ev_raw (ev_raw),
    .od_raw (od_raw),
    .ev_vld (ev_vld_r[s1_dec_r.ev_addr]),
    .od_vld (od_vld_r[s1_dec_r.od_addr]),
    .ev_fwd (ev_fwd_r),
    .od_fwd (od_fwd_r),
    .res    (res),
    .ev_wr  (ev_wr),
    .od_wr  (od_wr)
  );

  crs_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_vld_r),
    .push_item (res),
    .pop       (out_tready),
    .not_empty (q_not_empty),
    .head      (head),
    .cnt       (q_cnt)
  );

  assign out_tvalid = q_not_empty;
  assign out_tdata  = head.read_byte;
  assign out_tuser  = head.status;

  // chunks in flight never outgrow the result queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    in_flight <= 3'd3)
    else $error("result queue overflow");

  // an accepted beat is in the merge stage on the next cycle
  a_beat_to_merge: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> s1_vld_r)
    else $error("accepted beat lost before merge");

  // store is written only by a good write chunk
  a_write_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (ev_wr.en || od_wr.en) |-> (s1_vld_r && s1_dec_r.op_wr && s1_dec_r.status == ST_OK))
    else $error("store written by a failed or read chunk");

  // failed chunks return zero data
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != ST_OK) |-> (out_tdata == 8'd0))
    else $error("nonzero data on a failed chunk");

endmodule

FILE: test/tb.sv
// testbench of the coil bit range store: directed table, then random transfers
`timescale 1ns / 1ps

module tb;
  import crs_pkg::*;

  // one row of the directed table; want is used only where typed is set
  typedef struct packed {
    logic        op;
    logic [15:0] addr;
    logic [15:0] cnt;
    logic [7:0]  chunk;
    logic [7:0]  wb;
    logic        typed;
    out_item_t   want;
  } dir_row_t;

  localparam int DIR_ROWS = 25;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [11:0] cfg_data;    // coils_in_use
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;    // start_address, bit_count, chunk_index, write_byte
  logic [0:0]  in_tuser;    // op
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;   // read_byte
  logic [1:0]  out_tuser;   // status

  // predictor state: its own copy of the coil bytes and of coils_in_use
  logic [7:0]  coil_bytes [STORE_BYTES];
  logic [11:0] coil_count;
  out_item_t   pending_results [$];

  int fail_count = 0;
  int items_sent = 0;
  bit idle_on    = 1'b1;

  dir_row_t dir_table [DIR_ROWS] = '{
    // store reads as all off straight after reset, at both ends
    '{OP_READ,  16'd0,     16'd8,     8'd0,   8'h00, 1'b1, '{ST_OK,     8'h00}},
    '{OP_READ,  16'd2040,  16'd8,     8'd0,   8'h00, 1'b1, '{ST_OK,     8'h00}},
    // zero count
    '{OP_READ,  16'd0,     16'd0,     8'd0,   8'h00, 1'b1, '{ST_RANGE,  8'h00}},
    // address plus count must not wrap at 16 bits
    '{OP_WRITE, 16'd65535, 16'd65535, 8'd0,   8'hff, 1'b1, '{ST_RANGE,  8'h00}},
    '{OP_READ,  16'd2047,  16'd2,     8'd0,   8'h00, 1'b1, '{ST_RANGE,  8'h00}},
    // chunk beyond the transfer
    '{OP_READ,  16'd0,     16'd8,     8'd1,   8'h00, 1'b1, '{ST_BEYOND, 8'h00}},
    '{OP_WRITE, 16'd0,     16'd16,    8'd255, 8'hff, 1'b1, '{ST_BEYOND, 8'h00}},
    // range error wins over chunk beyond
    '{OP_READ,  16'd0,     16'd0,     8'd255, 8'h00, 1'b1, '{ST_RANGE,  8'h00}},
    // aligned write then read back, write result is zero
    '{OP_WRITE, 16'd0,     16'd8,     8'd0,   8'hff, 1'b1, '{ST_OK,     8'h00}},
    '{OP_READ,  16'd0,     16'd8,     8'd0,   8'h00, 1'b1, '{ST_OK,     8'hff}},
    // failed write leaves the store alone
    '{OP_WRITE, 16'd0,     16'd0,     8'd0,   8'h00, 1'b1, '{ST_RANGE,  8'h00}},
    '{OP_READ,  16'd0,     16'd8,     8'd0,   8'h00, 1'b1, '{ST_OK,     8'hff}},
    // unaligned write across two bytes, last chunk partial
    '{OP_WRITE, 16'd3,     16'd13,    8'd0,   8'ha5, 1'b1, '{ST_OK,     8'h00}},
    '{OP_WRITE, 16'd3,     16'd13,    8'd1,   8'hff, 1'b1, '{ST_OK,     8'h00}},
    '{OP_READ,  16'd3,     16'd13,    8'd0,   8'h00, 1'b0, '{ST_OK,     8'h00}},
    '{OP_READ,  16'd3,     16'd13,    8'd1,   8'h00, 1'b0, '{ST_OK,     8'h00}},
    '{OP_READ,  16'd0,     16'd16,    8'd1,   8'h00, 1'b0, '{ST_OK,     8'h00}},
    // last coil of the store
    '{OP_WRITE, 16'd2047,  16'd1,     8'd0,   8'hff, 1'b1, '{ST_OK,     8'h00}},
    '{OP_READ,  16'd2040,  16'd8,     8'd0,   8'h00, 1'b0, '{ST_OK,     8'h00}},
    // write data past the end of the transfer is dropped
    '{OP_WRITE, 16'd2044,  16'd4,     8'd0,   8'hf0, 1'b0, '{ST_OK,     8'h00}},
    // highest chunk index of a full-size transfer
    '{OP_WRITE, 16'd1,     16'd2047,  8'd255, 8'h7f, 1'b0, '{ST_OK,     8'h00}},
    '{OP_READ,  16'd1,     16'd2047,  8'd255, 8'h00, 1'b0, '{ST_OK,     8'h00}},
    '{OP_READ,  16'd0,     16'd2048,  8'd255, 8'h00, 1'b0, '{ST_OK,     8'h00}},
    '{OP_READ,  16'd65535, 16'd1,     8'd0,   8'h00, 1'b1, '{ST_RANGE,  8'h00}},
    '{OP_WRITE, 16'd2040,  16'd8,     8'd0,   8'h55, 1'b1, '{ST_OK,     8'h00}}
  };

  coil_bit_range_store i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // generous overall limit, far beyond the slowest correct run
  initial begin
    #10000000;
    $display("simulation failed");
    $finish;
  end

  // works out what one chunk returns and applies a write to the coil bytes
  function automatic out_item_t predict_chunk(input logic op, input logic [15:0] addr,
                                              input logic [15:0] cnt, input logic [7:0] chunk,
                                              input logic [7:0] wb);
    int          lim;
    int          first;
    int          nbits;
    int          base;
    int          bidx;
    int          off;
    logic [15:0] mask;
    logic [15:0] m;
    logic [15:0] d;
    logic [15:0] wide;
    out_item_t   res;
    res.status    = ST_OK;
    res.read_byte = 8'h00;
    lim = (int'(coil_count) > NUM_COILS) ? NUM_COILS : int'(coil_count);
    // full-width sum, so no wrap past 65535
    if (cnt == 16'd0 || int'(addr) + int'(cnt) > lim) begin
      res.status = ST_RANGE;
      return res;
    end
    first = int'(chunk) * BYTE_BITS;
    if (first >= int'(cnt)) begin
      res.status = ST_BEYOND;
      return res;
    end
    nbits = int'(cnt) - first;
    if (nbits > BYTE_BITS) nbits = BYTE_BITS;
    mask = 16'((1 << nbits) - 1);
    base = int'(addr) + first;
    bidx = base / BYTE_BITS;
    off  = base % BYTE_BITS;
    if (bidx >= STORE_BYTES) begin
      res.status = ST_RANGE;
      return res;
    end
    if (op == OP_READ) begin
      wide = {(bidx + 1 < STORE_BYTES) ? coil_bytes[bidx + 1] : 8'h00, coil_bytes[bidx]};
      res.read_byte = 8'((wide >> off) & mask);
    end else begin
      m = mask << off;
      d = ({8'h00, wb} & mask) << off;
      coil_bytes[bidx] = (coil_bytes[bidx] & ~m[7:0]) | (d[7:0] & m[7:0]);
      if (bidx + 1 < STORE_BYTES) begin
        coil_bytes[bidx + 1] = (coil_bytes[bidx + 1] & ~m[15:8]) | (d[15:8] & m[15:8]);
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    fail_count++;
    if (fail_count <= 40) begin
      $display("%0t mismatch: %s got %0h want %0h", $time, what, got, want);
    end
  endtask

  // presents one chunk beat, holds it until taken, then queues its result
  task automatic send_chunk(input logic op, input logic [15:0] addr, input logic [15:0] cnt,
                            input logic [7:0] chunk, input logic [7:0] wb,
                            input logic typed, input out_item_t want);
    out_item_t predicted;
    if (idle_on && $urandom_range(7, 0) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(19, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {wb, chunk, cnt, addr};
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    // the predictor runs on every beat so that writes reach its store
    predicted = predict_chunk(op, addr, cnt, chunk, wb);
    pending_results.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  // new coils_in_use, only once every pending result is out
  task automatic set_coil_count(input logic [11:0] value);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    coil_count = value;
  endtask

  // mostly well-formed transfers, some broken ones, some pure noise
  task automatic run_transfers(input int n);
    int   target;
    int   lim;
    int   pick;
    int   cnt;
    int   addr;
    int   span;
    int   nchunks;
    logic op;
    target = items_sent + n;
    while (items_sent < target) begin
      lim  = (int'(coil_count) > NUM_COILS) ? NUM_COILS : int'(coil_count);
      pick = $urandom_range(99, 0);
      op   = 1'($urandom_range(1, 0));
      if (lim == 0 || pick < 12) begin
        send_chunk(op, 16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom), 1'b0, '0);
      end else begin
        // small sizes most of the time, the full store only now and then
        if (pick < 80) cnt = $urandom_range((lim < 24) ? lim : 24, 1);
        else if (pick < 98) cnt = $urandom_range((lim < 200) ? lim : 200, 1);
        else cnt = $urandom_range(lim, 1);
        span = lim - cnt;
        // a narrow window keeps neighbouring chunks on the same bytes
        if ($urandom_range(9, 0) < 6) addr = $urandom_range((span < 31) ? span : 31, 0);
        else addr = $urandom_range(span, 0);
        nchunks = (cnt + 7) / 8;
        if (pick < 18) begin
          if ($urandom_range(1, 0) == 0) begin
            // one coil past the end of the store in use
            send_chunk(op, 16'(addr), 16'(lim - addr + 1), 8'($urandom_range(nchunks - 1, 0)),
                       8'($urandom), 1'b0, '0);
          end else begin
            send_chunk(op, 16'(addr), 16'(cnt), 8'(nchunks + $urandom_range(3, 0)),
                       8'($urandom), 1'b0, '0);
          end
        end else begin
          for (int k = 0; k < nchunks; k++) begin
            send_chunk(op, 16'(addr), 16'(cnt), 8'(k), 8'($urandom), 1'b0, '0);
          end
          // read back part of the writes straight away
          if (op == OP_WRITE && $urandom_range(2, 0) == 0) begin
            for (int k = 0; k < nchunks; k++) begin
              send_chunk(OP_READ, 16'(addr), 16'(cnt), 8'(k), 8'($urandom), 1'b0, '0);
            end
          end
        end
      end
    end
  endtask

  // result side back-pressure in random bursts
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(9, 0) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(19, 1)) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // each result beat against the oldest pending result
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing pending", int'(out_tdata), 0);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata !== want.read_byte) begin
          report_mismatch("read_byte", int'(out_tdata), int'(want.read_byte));
        end
        if (out_tuser !== want.status) begin
          report_mismatch("status", int'(out_tuser), int'(want.status));
        end
      end
    end
  end

  initial begin
    rst_n     <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    foreach (coil_bytes[i]) coil_bytes[i] = 8'h00;
    coil_count = CIU_RESET;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part under the reset value of coils_in_use
    foreach (dir_table[i]) begin
      send_chunk(dir_table[i].op, dir_table[i].addr, dir_table[i].cnt, dir_table[i].chunk,
                 dir_table[i].wb, dir_table[i].typed, dir_table[i].want);
    end

    // random phases over several store sizes, extremes included
    set_coil_count(12'd4095);
    run_transfers(350);
    set_coil_count(12'd1);
    run_transfers(60);
    set_coil_count(12'd0);
    run_transfers(40);
    set_coil_count(12'd17);
    run_transfers(150);
    set_coil_count(12'($urandom_range(2047, 2)));
    run_transfers(350);
    set_coil_count(12'd2048);
    run_transfers(400);
    // last stretch at full rate on both sides
    idle_on = 1'b0;
    run_transfers(400);

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
